// ----- rtl/pcf_pkg.sv -----
// Shared types and constants for the Pascal case folder.
// Lexical context encoding and the ASCII codes that steer it.
// No dependencies.
package pcf_pkg;

    typedef enum logic [2:0] {
        CTX_PLAIN       = 3'd0,
        CTX_BRACE       = 3'd1,
        CTX_AFTER_PAREN = 3'd2,
        CTX_PSTAR       = 3'd3,
        CTX_PSTAR_STAR  = 3'd4,
        CTX_STRING      = 3'd5,
        CTX_STRING_QUOT = 3'd6
    } ctx_t;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

endpackage

// ----- rtl/pcf_lexer.sv -----
// Combinational lexer step: next lexical context and the emitted byte.
// Depends on pcf_pkg for ctx_t and character codes.
module pcf_lexer (
    input  pcf_pkg::ctx_t     ctx,
    input  logic [7:0]        in_byte,
    input  logic              first_of_file,
    output pcf_pkg::ctx_t     ctx_next,
    output logic [7:0]        out_byte
);
    import pcf_pkg::*;

    ctx_t       ctx_eff;
    logic       is_upper;
    logic [7:0] folded;
    ctx_t       plain_ctx;

    assign ctx_eff  = first_of_file ? CTX_PLAIN : ctx;
    assign is_upper = (in_byte >= CH_UPPER_A) && (in_byte <= CH_UPPER_Z);
    assign folded   = is_upper ? (in_byte | CASE_BIT) : in_byte;

    // context a plain-text byte leads to
    always_comb
    begin
        case (in_byte)
            CH_LBRACE: plain_ctx = CTX_BRACE;
            CH_LPAREN: plain_ctx = CTX_AFTER_PAREN;
            CH_QUOTE:  plain_ctx = CTX_STRING;
            default:   plain_ctx = CTX_PLAIN;
        endcase
    end

    // next state
    always_comb
    begin
        case (ctx_eff)
            CTX_BRACE:
                ctx_next = (in_byte == CH_RBRACE) ? CTX_PLAIN : CTX_BRACE;
            CTX_AFTER_PAREN:
                ctx_next = (in_byte == CH_STAR) ? CTX_PSTAR : plain_ctx;
            CTX_PSTAR:
                ctx_next = (in_byte == CH_STAR) ? CTX_PSTAR_STAR : CTX_PSTAR;
            CTX_PSTAR_STAR:
                if (in_byte == CH_RPAREN)
                    ctx_next = CTX_PLAIN;
                else
                    ctx_next = (in_byte == CH_STAR) ? CTX_PSTAR_STAR : CTX_PSTAR;
            CTX_STRING:
                ctx_next = (in_byte == CH_QUOTE) ? CTX_STRING_QUOT : CTX_STRING;
            CTX_STRING_QUOT:
                ctx_next = (in_byte == CH_QUOTE) ? CTX_STRING : plain_ctx;
            default:
                ctx_next = plain_ctx;
        endcase
    end

    // output byte: folded only when the byte is read as plain text
    always_comb
    begin
        case (ctx_eff)
            CTX_BRACE, CTX_PSTAR, CTX_PSTAR_STAR, CTX_STRING:
                out_byte = in_byte;
            CTX_AFTER_PAREN:
                out_byte = (in_byte == CH_STAR) ? in_byte : folded;
            CTX_STRING_QUOT:
                out_byte = (in_byte == CH_QUOTE) ? in_byte : folded;
            default:
                out_byte = folded;
        endcase
    end

endmodule

// ----- rtl/pascal_case_folder.sv -----
// Top level of the Pascal case folder: context register and output register.
// Depends on pcf_pkg and pcf_lexer.
//
// Takes one byte of Pascal source per word and returns one byte per word,
// lower-casing A..Z in plain text and passing comments and strings unchanged.
// A byte is taken whenever in_ready is high; its result appears in the output
// register in the cycle after acceptance. Throughput is one word per cycle
// while the output is not stalled, set by the context update loop; the output
// register lets a new word in whenever the held result is taken in the same
// cycle. first_of_file clears the context before its byte is handled.
module pascal_case_folder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       first_of_file,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte
);
    import pcf_pkg::*;

    ctx_t       ctx_reg;
    ctx_t       ctx_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       accept;

    pcf_lexer u_lexer (
        .ctx           (ctx_reg),
        .in_byte       (in_byte),
        .first_of_file (first_of_file),
        .ctx_next      (ctx_next),
        .out_byte      (out_byte_next)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg       <= CTX_PLAIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                ctx_reg <= ctx_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_byte_reg <= out_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    // every accepted word yields a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted word produced no result");

    // an empty output stage never back-pressures the source
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output register");

    // string bodies pass bytes untouched
    a_string_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !first_of_file && ctx_reg == CTX_STRING)
        |=> out_byte == $past(in_byte))
        else $error("byte altered inside string");

    // start of file with an ordinary byte leaves plain text
    a_first_plain: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && first_of_file && in_byte != CH_LBRACE
         && in_byte != CH_LPAREN && in_byte != CH_QUOTE)
        |=> ctx_reg == CTX_PLAIN)
        else $error("context not plain after start of file");

endmodule
